/* rtl/core/osm_pkg.sv */
// shared types and constants for the order statistic multiset
`default_nettype none
package osm_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_RANK   = 2'd2,
    OP_SELECT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic [23:0]        position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [24:0]        result_rank;
    logic [1:0]         status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, clear scan state
    logic scan;      // read-and-compare one entry per cycle
    logic shift;     // move one entry up or down
    logic write;     // final write of entry / count update
    logic respond;   // register the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic need_shift;
    logic need_write;
  } sts_t;

  localparam logic [24:0] RANK_MAX = 25'h1FF_FFFF;

endpackage
`default_nettype wire

/* rtl/core/osm_ctrl.sv */
// control state machine for the order statistic multiset
`default_nettype none
module osm_ctrl
  import osm_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  req_valid_i,
  output logic req_stall_o,
  output logic rsp_valid_o,
  input  wire  rsp_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    cmd_o   = '0;
    req_stall_o = 1'b1;
    if (valid_q && !rsp_stall_i) valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_stall_o = 1'b0;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.need_shift) state_d = S_SHIFT;
          else if (sts_i.need_write) state_d = S_WRITE;
          else state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        // the output register may still hold the previous result
        if (!valid_q || !rsp_stall_i) begin
          cmd_o.respond = 1'b1;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_valid_o = valid_q;

endmodule
`default_nettype wire

/* rtl/core/osm_dp.sv */
// datapath of the order statistic multiset: entry memories, scan and shift
`default_nettype none
module osm_dp
  import osm_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int COUNT_BITS = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output rsp_t rsp_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int UW = $clog2(CAPACITY + 1);
  localparam int TW = COUNT_BITS + AW + 1;
  localparam int PW = (TW > 24) ? TW + 1 : 25;
  localparam logic [UW-1:0] CAP = UW'(CAPACITY);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [COUNT_BITS-1:0] cnt_mem [CAPACITY];

  op_e                   op_q;
  logic [VALUE_BITS-1:0] key_q;
  logic [23:0]           pos_q;
  logic [UW-1:0]         used_q, used_d;
  logic [UW-1:0]         idx_q;   // scan index / shift pointer
  logic                  rd_pend_q;
  logic [VALUE_BITS-1:0] rd_val_q;
  logic [COUNT_BITS-1:0] rd_cnt_q;
  logic [TW-1:0]         acc_q;   // copies below current entry
  logic                  hit_q, found_q, done_q;
  logic                  full_q;  // insert refused
  logic [UW-1:0]         at_q;    // lower-bound index
  logic [COUNT_BITS-1:0] hcnt_q;
  logic [VALUE_BITS-1:0] sel_q;
  logic [VALUE_BITS-1:0] shv_q;
  logic [COUNT_BITS-1:0] shc_q;
  logic                  shp_q;   // shift read pending
  rsp_t                  rsp_q, rsp_d;

  logic less, equal;
  logic [TW-1:0] acc_n;
  logic [PW-1:0] pos_ext, acc_ext;

  assign less    = $signed(rd_val_q) < $signed(key_q);
  assign equal   = rd_val_q == key_q;
  assign acc_n   = acc_q + TW'(rd_cnt_q);
  assign pos_ext = PW'(pos_q);
  assign acc_ext = PW'(acc_n);

  // decide actions from scan outcome
  logic ins_new, del_last;
  assign ins_new  = (op_q == OP_INSERT) && !hit_q && (used_q < CAP);
  assign del_last = (op_q == OP_DELETE) && hit_q && (hcnt_q == COUNT_BITS'(1));

  assign sts_o.scan_done  = done_q;
  assign sts_o.need_shift = (ins_new && (at_q != used_q)) ||
                            (del_last && (at_q + UW'(1) != used_q));
  assign sts_o.need_write = ins_new || del_last ||
                            (hit_q && (op_q == OP_DELETE)) ||
                            (hit_q && (op_q == OP_INSERT) && hcnt_q != CNT_MAX);
  assign sts_o.shift_done = ins_new ? (idx_q == at_q && !shp_q)
                                    : (idx_q + UW'(1) == used_q && !shp_q);

  // memory ports: read one, write one per cycle
  logic [AW-1:0] raddr;
  logic          ren;
  always_comb begin
    raddr = idx_q[AW-1:0];
    ren   = 1'b0;
    if (cmd_i.scan && !done_q && idx_q < used_q) ren = 1'b1;
    if (cmd_i.shift && !shp_q) begin
      ren = 1'b1;
      raddr = ins_new ? AW'(idx_q - UW'(1)) : AW'(idx_q + UW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ren) begin
      rd_val_q <= val_mem[raddr];
      rd_cnt_q <= cnt_mem[raddr];
    end
    if (cmd_i.shift && shp_q) begin
      val_mem[idx_q[AW-1:0]] <= shv_q;
      cnt_mem[idx_q[AW-1:0]] <= shc_q;
    end
    if (cmd_i.write) begin
      if (ins_new) begin
        val_mem[at_q[AW-1:0]] <= key_q;
        cnt_mem[at_q[AW-1:0]] <= COUNT_BITS'(1);
      end else if (!del_last) begin
        cnt_mem[at_q[AW-1:0]] <= (op_q == OP_INSERT) ? hcnt_q + COUNT_BITS'(1)
                                                      : hcnt_q - COUNT_BITS'(1);
      end
    end
  end

  always_comb begin
    used_d = used_q;
    if (cmd_i.write) begin
      if (ins_new) used_d = used_q + UW'(1);
      else if (del_last) used_d = used_q - UW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_e'(req_i.op);
      key_q     <= VALUE_BITS'($unsigned(req_i.value));
      pos_q     <= req_i.position;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      acc_q     <= '0;
      hit_q     <= 1'b0;
      found_q   <= 1'b0;
      done_q    <= 1'b0;
      full_q    <= 1'b0;
      at_q      <= '0;
      hcnt_q    <= '0;
      sel_q     <= '0;
      shp_q     <= 1'b0;
    end else if (cmd_i.scan && !done_q) begin
      rd_pend_q <= ren;
      if (ren) idx_q <= idx_q + UW'(1);
      if (rd_pend_q) begin
        if (op_q == OP_SELECT) begin
          if (pos_q != '0 && pos_ext <= acc_ext) begin
            found_q <= 1'b1;
            sel_q   <= rd_val_q;
            done_q  <= 1'b1;
          end
          acc_q <= acc_n;
        end else if (less) begin
          acc_q <= acc_n;
          at_q  <= at_q + UW'(1);
        end else begin
          hit_q  <= equal;
          hcnt_q <= rd_cnt_q;
          done_q <= 1'b1;
        end
      end
      if (!ren && !rd_pend_q) begin
        done_q <= 1'b1;
        // shift pointer starts at the top for inserts, at the hole for deletes
        idx_q  <= (op_q == OP_INSERT) ? used_q : at_q;
      end
    end else if (cmd_i.scan && done_q) begin
      idx_q  <= (op_q == OP_INSERT) ? used_q : at_q;
      // decided before the write can change the entry count
      full_q <= (op_q == OP_INSERT) && (hit_q ? hcnt_q == CNT_MAX : used_q >= CAP);
    end else if (cmd_i.shift) begin
      if (!shp_q) begin
        shp_q <= 1'b1;
      end else begin
        shp_q <= 1'b0;
        idx_q <= ins_new ? idx_q - UW'(1) : idx_q + UW'(1);
      end
    end
  end

  always_comb begin
    shv_q = rd_val_q;
    shc_q = rd_cnt_q;
  end

  // result
  logic [31:0] sel_out;
  logic [TW:0] rank_full;
  assign sel_out   = 32'($signed(sel_q));
  assign rank_full = {1'b0, acc_q} + (TW+1)'(1);

  always_comb begin
    rsp_d = '0;
    case (op_q)
      OP_INSERT: begin
        if (full_q) rsp_d.status = ST_FULL;
      end
      OP_DELETE: if (!hit_q) rsp_d.status = ST_NOTFOUND;
      OP_RANK: begin
        if (!hit_q) rsp_d.status = ST_NOTFOUND;
        else if (rank_full > (TW+1)'(RANK_MAX)) rsp_d.result_rank = RANK_MAX;
        else rsp_d.result_rank = 25'(rank_full);
      end
      OP_SELECT: begin
        if (found_q) rsp_d.result_value = sel_out;
        else rsp_d.status = ST_NOTFOUND;
      end
      default: rsp_d.status = ST_NOTFOUND;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

/* rtl/core/order_statistic_multiset.sv */
// Bounded multiset of signed values kept as a sorted table of distinct values with
// copy counts in two single-port memories. Every request (insert, delete, rank,
// select) gives one result. A request scans the table from the bottom, one entry
// per cycle over the memory read port; an insert of a new value or a delete of a
// last copy also moves the entries above it by one place, reading and then
// writing each entry. The next request is taken once the result is registered.
// No clearing pass is needed after reset.
`default_nettype none
module order_statistic_multiset
  import osm_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int COUNT_BITS = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  wire  rsp_stall_i,
  output rsp_t rsp_o
);

  cmd_t cmd;
  sts_t sts;

  osm_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o,
    .rsp_valid_o, .rsp_stall_i, .sts_i(sts), .cmd_o(cmd)
  );

  osm_dp #(
    .CAPACITY(CAPACITY), .COUNT_BITS(COUNT_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );

endmodule
`default_nettype wire

/* rtl/core/osm_checker.sv */
// port-level checks for the order statistic multiset
`default_nettype none
module osm_checker
  import osm_pkg::*;
(
  input wire  clk_i,
  input wire  rst_ni,
  input wire  req_valid_i,
  input wire  req_stall_o,
  input wire  rsp_valid_o,
  input wire  rsp_stall_i,
  input rsp_t rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.status != 2'd3)
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != ST_OK |-> rsp_o.result_value == '0 &&
    rsp_o.result_rank == '0)
    else $error("failed request carries data");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o)
    else $error("second request taken before first finished");

endmodule

bind order_statistic_multiset osm_checker u_osm_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .rsp_valid_o, .rsp_stall_i, .rsp_o
);
`default_nettype wire
